[sv/sed_pkg.sv]
// types and constants shared by the string escape decoder modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

	typedef enum logic [2:0] {
		MODE_PLAIN = 3'd0,
		MODE_ESC   = 3'd1,
		MODE_CR    = 3'd2,
		MODE_XU    = 3'd3,
		MODE_FIXED = 3'd4,
		MODE_BRACE = 3'd5,
		MODE_SKIP  = 3'd6
	} mode_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [15:0] decoded_unit;
		logic        unit_valid;
		logic        string_done;
	} out_item_t;

	typedef struct packed {
		mode_t       parse_mode;
		logic [2:0]  digits_left;
		logic        brace_seen_digit;
		logic [20:0] code_value;
	} parse_state_t;

	// results of one transaction, count says how many of res0/res1 are used
	typedef struct packed {
		out_item_t  res0;
		out_item_t  res1;
		logic [1:0] count;
	} step_res_t;

	localparam logic [15:0] CH_NUL       = 16'h0000;
	localparam logic [15:0] CH_TAB       = 16'h0009;
	localparam logic [15:0] CH_LF        = 16'h000A;
	localparam logic [15:0] CH_CR        = 16'h000D;
	localparam logic [15:0] CH_BACKSLASH = 16'h005C;
	localparam logic [15:0] CH_T         = 16'h0074;
	localparam logic [15:0] CH_U         = 16'h0075;
	localparam logic [15:0] CH_X         = 16'h0078;
	localparam logic [15:0] CH_LBRACE    = 16'h007B;
	localparam logic [15:0] CH_RBRACE    = 16'h007D;
	localparam logic [15:0] UNIT_ERR     = 16'hFFFD;
	localparam logic [15:0] HI_SURR      = 16'hD800;
	localparam logic [15:0] LO_SURR      = 16'hDC00;
	localparam logic [20:0] SUPP_BASE    = 21'h010000;
	localparam logic [24:0] CODE_MAX     = 25'h010FFFF;

	localparam logic [2:0]  DIGITS_X     = 3'd2;
	localparam logic [2:0]  DIGITS_U     = 3'd4;

	localparam parse_state_t STATE_RESET = '{
		parse_mode:       MODE_PLAIN,
		digits_left:      3'd0,
		brace_seen_digit: 1'b0,
		code_value:       21'd0
	};

endpackage

`default_nettype wire

[sv/sed_step.sv]
// next-state and result logic for one code unit of the escape decoder
// depends on sed_pkg
`timescale 1ns / 1ps
`default_nettype none

module sed_step (
	input  wire sed_pkg::in_item_t     item,
	input  wire sed_pkg::parse_state_t state,
	output sed_pkg::parse_state_t      state_next,
	output sed_pkg::step_res_t         res
);

	function automatic logic [4:0] hex_digit(input logic [15:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 16'h0030 && c <= 16'h0039) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 16'h0041 && c <= 16'h0046) || (c >= 16'h0061 && c <= 16'h0066)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	logic [15:0]          u;
	logic [4:0]           hex_r;
	logic                 hex_ok;
	logic [3:0]           hex_v;
	logic [24:0]          brace_v;
	logic [20:0]          fixed_v;
	logic [2:0]           fixed_left;
	logic                 do_plain;
	logic                 do_fixed;
	logic                 emit_unit;
	logic [15:0]          unit_x;
	logic                 emit_code;
	logic [20:0]          code_src;
	logic [20:0]          supp_w;
	logic                 pending;
	logic [15:0]          e0;
	logic [15:0]          e1;
	logic [1:0]           ne;
	sed_pkg::parse_state_t nxt;

	assign u          = item.code_unit;
	assign hex_r      = hex_digit(u);
	assign hex_ok     = hex_r[4];
	assign hex_v      = hex_r[3:0];
	assign brace_v    = {state.code_value, hex_v};
	assign fixed_v    = {state.code_value[16:0], hex_v};
	assign fixed_left = state.digits_left - 3'd1;
	assign supp_w     = code_src - sed_pkg::SUPP_BASE;

	// decode of the current unit
	always_comb begin
		nxt       = state;
		do_plain  = 1'b0;
		do_fixed  = 1'b0;
		emit_unit = 1'b0;
		unit_x    = sed_pkg::UNIT_ERR;
		emit_code = 1'b0;
		code_src  = state.code_value;
		case (state.parse_mode)
			sed_pkg::MODE_ESC: begin
				nxt.parse_mode = sed_pkg::MODE_PLAIN;
				if (u == sed_pkg::CH_NUL) begin
					nxt.parse_mode = sed_pkg::MODE_SKIP;
				end else if (u == sed_pkg::CH_BACKSLASH) begin
					emit_unit = 1'b1;
					unit_x    = sed_pkg::CH_BACKSLASH;
				end else if (u == sed_pkg::CH_CR) begin
					nxt.parse_mode = sed_pkg::MODE_CR;
				end else if (u == sed_pkg::CH_LF) begin
					nxt.parse_mode = sed_pkg::MODE_PLAIN;
				end else if (u == sed_pkg::CH_T) begin
					emit_unit = 1'b1;
					unit_x    = sed_pkg::CH_TAB;
				end else if (u == sed_pkg::CH_X || u == sed_pkg::CH_U) begin
					nxt.parse_mode       = sed_pkg::MODE_XU;
					nxt.digits_left      = (u == sed_pkg::CH_X) ? sed_pkg::DIGITS_X
										 : sed_pkg::DIGITS_U;
					nxt.code_value       = 21'd0;
					nxt.brace_seen_digit = 1'b0;
				end else begin
					emit_unit = 1'b1;
				end
			end
			sed_pkg::MODE_CR: begin
				nxt.parse_mode = sed_pkg::MODE_PLAIN;
				do_plain       = (u != sed_pkg::CH_LF);
			end
			sed_pkg::MODE_XU: begin
				if (u == sed_pkg::CH_LBRACE) begin
					nxt.parse_mode       = sed_pkg::MODE_BRACE;
					nxt.code_value       = 21'd0;
					nxt.brace_seen_digit = 1'b0;
				end else begin
					do_fixed = 1'b1;
				end
			end
			sed_pkg::MODE_FIXED: begin
				do_fixed = 1'b1;
			end
			sed_pkg::MODE_BRACE: begin
				if (state.brace_seen_digit && u == sed_pkg::CH_RBRACE) begin
					emit_code      = 1'b1;
					nxt.parse_mode = sed_pkg::MODE_PLAIN;
				end else if (!hex_ok || brace_v > sed_pkg::CODE_MAX) begin
					emit_unit      = 1'b1;
					nxt.parse_mode = sed_pkg::MODE_PLAIN;
				end else begin
					nxt.code_value       = brace_v[20:0];
					nxt.brace_seen_digit = 1'b1;
				end
			end
			sed_pkg::MODE_SKIP: begin
				nxt.parse_mode = sed_pkg::MODE_SKIP;
			end
			default: begin
				nxt.parse_mode = sed_pkg::MODE_PLAIN;
				do_plain       = 1'b1;
			end
		endcase

		if (do_fixed) begin
			if (!hex_ok) begin
				emit_unit      = 1'b1;
				nxt.parse_mode = sed_pkg::MODE_PLAIN;
			end else begin
				nxt.code_value  = fixed_v;
				nxt.digits_left = fixed_left;
				if (fixed_left == 3'd0) begin
					emit_code      = 1'b1;
					code_src       = fixed_v;
					nxt.parse_mode = sed_pkg::MODE_PLAIN;
				end else begin
					nxt.parse_mode = sed_pkg::MODE_FIXED;
				end
			end
		end

		if (do_plain) begin
			if (u == sed_pkg::CH_NUL) begin
				nxt.parse_mode = sed_pkg::MODE_SKIP;
			end else if (u == sed_pkg::CH_BACKSLASH) begin
				nxt.parse_mode = sed_pkg::MODE_ESC;
			end else begin
				emit_unit = 1'b1;
				unit_x    = u;
			end
		end
	end

	// result assembly and end of string
	always_comb begin
		e0 = 16'd0;
		e1 = 16'd0;
		ne = 2'd0;
		if (emit_code) begin
			if (code_src[20:16] == 5'd0) begin
				e0 = code_src[15:0];
				ne = 2'd1;
			end else begin
				e0 = sed_pkg::HI_SURR + {6'd0, supp_w[19:10]};
				e1 = sed_pkg::LO_SURR + {6'd0, supp_w[9:0]};
				ne = 2'd2;
			end
		end else if (emit_unit) begin
			e0 = unit_x;
			ne = 2'd1;
		end

		pending = nxt.parse_mode == sed_pkg::MODE_XU || nxt.parse_mode == sed_pkg::MODE_FIXED
			|| nxt.parse_mode == sed_pkg::MODE_BRACE;

		res.res0 = '{decoded_unit: e0, unit_valid: 1'b1, string_done: 1'b0};
		res.res1 = '{decoded_unit: e1, unit_valid: 1'b1, string_done: 1'b0};
		res.count = ne;
		state_next = nxt;

		if (item.end_of_text) begin
			state_next = sed_pkg::STATE_RESET;
			if (pending) begin
				// pending escapes never emit, so this is the only result
				res.res0.decoded_unit = sed_pkg::UNIT_ERR;
				res.res0.string_done  = 1'b1;
				res.count             = 2'd1;
			end else if (ne == 2'd0) begin
				res.res0   = '{decoded_unit: 16'd0, unit_valid: 1'b0, string_done: 1'b1};
				res.count  = 2'd1;
			end else if (ne == 2'd1) begin
				res.res0.string_done = 1'b1;
			end else begin
				res.res1.string_done = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[sv/sed_outq.sv]
// result queue of the escape decoder, takes up to two results per cycle
// depends on sed_pkg
`timescale 1ns / 1ps
`default_nettype none

module sed_outq #(
	parameter int DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_en,
	input  wire sed_pkg::step_res_t  push,
	output logic                     space,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output sed_pkg::out_item_t       result
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	sed_pkg::out_item_t mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [1:0]         push_n;
	logic               pop;

	assign push_n       = push_en ? push.count : 2'd0;
	assign pop          = result_valid && result_ready;
	assign result_valid = count_q != '0;
	assign result       = mem[rd_ptr_q];
	assign space        = count_q <= CNT_W'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_ptr_q] <= push.res0;
		end
		if (push_n == 2'd2) begin
			mem[wr_ptr_q + PTR_W'(1)] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue count above depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> ({1'b0, count_q} + (CNT_W+1)'(push_n)) <= (CNT_W+1)'(DEPTH))
		else $error("result queue overflow");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd0 && pop |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("result queue count not decremented");

endmodule

`default_nettype wire

[sv/string_escape_decoder_utf16.sv]
// top level of the utf-16 string literal escape decoder
// depends on sed_pkg, sed_step and sed_outq
`timescale 1ns / 1ps
`default_nettype none

// Decodes a string literal one UTF-16 code unit per transaction: plain units pass through,
// backslash escapes (\\, \t, line continuation, \xHH, \uHHHH, \x{..}, \u{..}) are
// decoded, code points above 0xFFFF leave as a surrogate pair, errors give U+FFFD, and
// the last result of a string carries string_done. A transaction is registered, decoded
// combinationally and its zero, one or two results are written into a result queue of
// OUTQ_DEPTH entries (a power of two, at least 2), so an input passes the input register
// and then the result queue on its way to the first result. The input side takes one code
// unit per cycle as long as the queue has room for two results; sustained throughput is
// one code unit per cycle, limited only by the output side draining one result per cycle
// while result_ready is held, when surrogate pairs or end marks add results.
module string_escape_decoder_utf16 #(
	parameter int OUTQ_DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire sed_pkg::in_item_t  item,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output sed_pkg::out_item_t      result
);

	logic                  valid_s1;
	sed_pkg::in_item_t     item_s1;
	sed_pkg::parse_state_t state_q;
	sed_pkg::parse_state_t state_next;
	sed_pkg::step_res_t    step_res;
	logic                  space;
	logic                  consume;

	assign consume    = valid_s1 && space;
	assign item_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sed_pkg::STATE_RESET;
		end else if (consume) begin
			state_q <= state_next;
		end
	end

	sed_step u_step (
		.item       (item_s1),
		.state      (state_q),
		.state_next (state_next),
		.res        (step_res)
	);

	sed_outq #(
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_en      (consume),
		.push         (step_res),
		.space        (space),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_bare_mark_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.unit_valid |-> result.string_done)
		else $error("bare end mark without string_done");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		consume && item_s1.end_of_text |-> step_res.count != 2'd0)
		else $error("final code unit produced no result");

	a_last_resets_state: assert property (@(posedge clk) disable iff (!arst_n)
		consume && item_s1.end_of_text |=>
			state_q.parse_mode == sed_pkg::MODE_PLAIN && state_q.code_value == 21'd0)
		else $error("parse state not reset after end of string");

endmodule

`default_nettype wire
